// File: hdl/deq_pkg.sv
// shared types and constants for the double-ended queue buffer
// no dependencies; compile first

package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    // word returned for an empty queue or a command that pops nothing
    localparam logic [WORD_W-1:0] NONE_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_NOP        = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

endpackage

// File: hdl/deq_if.sv
// valid/ready channels for the double-ended queue buffer
// depends on deq_pkg

interface deq_in_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_out_if #(
    parameter int COUNT_W = 11
);
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] popped_value;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic                     is_empty;

    modport source (
        output valid, output status, output popped_value, output count,
        output front_value, output back_value, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input popped_value, input count,
        input front_value, input back_value, input is_empty, output ready
    );
endinterface

// File: hdl/deq_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: hdl/double_ended_queue_buffer_top.sv
// top level of the double-ended queue buffer: index control, storage and result stage
// depends on deq_pkg, deq_if (deq_in_if, deq_out_if) and deq_ram

// Double-ended queue of DEPTH signed 32-bit words. Each input beat carries one
// command (push back, push front, pop front, pop back, no operation; codes 5 to 7
// act as no operation) and produces exactly one output beat with the status, the
// popped word, the count held afterwards, the front and back words and an empty
// flag (words read as -1 when there is none). A push is refused as overflow once
// the back position has reached DEPTH-1, even if words have since left the front.
// A new beat is taken every cycle while the output is not stalled; a beat's result
// passes through the input register, the registered read of the storage ram and
// the output register. The queue indices are updated as a command leaves the input
// register, so the next command sees them at once. The storage needs no clearing
// after reset: only written entries are ever read. Up to three beats can sit in the
// block while the output is stalled, so the input keeps accepting while a result waits.

module double_ended_queue_buffer_top #(
    parameter int DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_in_if.sink     i_in,
    deq_out_if.source  o_out
);
    import deq_pkg::*;

    // address, position and count widths
    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW:0]   DEPTH_L  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
    localparam logic [PW-1:0] POS_NONE = '1;
    localparam logic [PW-1:0] POS_ONE  = PW'(1);

    // logical position to physical ram address, ring wrap by one compare and subtract
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [PW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos[AW-1:0]};
        if (sum >= DEPTH_L) begin
            sum = sum - DEPTH_L;
        end
        return sum[AW-1:0];
    endfunction

    // handshake enables: each stage moves when the next one is free or moving
    logic out_en;
    logic b_en;
    logic a_en;
    logic a_move;

    // input register
    logic              r_a_vld;
    logic [CMD_W-1:0]  r_a_cmd;
    logic [WORD_W-1:0] r_a_word;

    // queue indices
    logic [AW-1:0] r_head;
    logic [PW-1:0] r_front;  // one before the first word, -1 while nothing has left
    logic [PW-1:0] r_back;   // last word, equal to r_front when empty

    logic [AW-1:0] n_head;
    logic [PW-1:0] n_front;
    logic [PW-1:0] n_back;

    // command decode results
    logic          q_empty;
    logic          q_full;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_f;
    logic [AW-1:0] rd_addr_b;
    t_status       a_status;
    logic          a_pop_f;
    logic          a_pop_b;
    logic [PW-1:0] a_count;

    // middle stage: decode results beside the ram read data
    logic              r_b_vld;
    t_status           r_b_status;
    logic              r_b_pop_f;
    logic              r_b_pop_b;
    logic [CW-1:0]     r_b_count;
    logic              r_b_empty;
    logic              r_b_byp_f;
    logic              r_b_byp_b;
    logic [WORD_W-1:0] r_b_word;
    logic [WORD_W-1:0] rd_data_f;
    logic [WORD_W-1:0] rd_data_b;

    logic [WORD_W-1:0] b_front;
    logic [WORD_W-1:0] b_back;
    logic [WORD_W-1:0] b_popped;

    // front and back words after the last result, source of the popped word
    logic [WORD_W-1:0] r_last_front;
    logic [WORD_W-1:0] r_last_back;

    // output register
    logic              r_o_vld;
    t_status           r_o_status;
    logic [WORD_W-1:0] r_o_popped;
    logic [CW-1:0]     r_o_count;
    logic [WORD_W-1:0] r_o_front;
    logic [WORD_W-1:0] r_o_back;
    logic              r_o_empty;

    assign out_en    = !r_o_vld || o_out.ready;
    assign b_en      = !r_b_vld || out_en;
    assign a_en      = !r_a_vld || b_en;
    assign a_move    = r_a_vld && b_en;
    assign i_in.ready = a_en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_en) begin
            r_a_vld <= i_in.valid;
        end
        if (a_en && i_in.valid) begin
            r_a_cmd  <= i_in.cmd;
            r_a_word <= i_in.push_value;
        end
    end

    // index update and ram addressing for the command in the input register
    always_comb begin
        q_empty  = (r_back == r_front);
        q_full   = (r_back == LAST_POS);
        n_head   = r_head;
        n_front  = r_front;
        n_back   = r_back;
        wr_en    = 1'b0;
        wr_addr  = f_phys(r_head, r_back + POS_ONE);
        a_status = ST_OK;
        a_pop_f  = 1'b0;
        a_pop_b  = 1'b0;
        unique case (t_cmd'(r_a_cmd))
            CMD_PUSH_BACK: begin
                if (q_full) begin
                    a_status = ST_OVERFLOW;
                end else begin
                    n_back = r_back + POS_ONE;
                    wr_en  = 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (q_full) begin
                    a_status = ST_OVERFLOW;
                end else if (r_front == POS_NONE) begin
                    // nothing left the front yet: slide the ring origin down one slot
                    n_head  = (r_head == '0) ? LAST_ADR : r_head - AW'(1);
                    n_back  = r_back + POS_ONE;
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                end else begin
                    // refill the free slot just before the first word
                    n_front = r_front - POS_ONE;
                    wr_en   = 1'b1;
                    wr_addr = f_phys(r_head, r_front);
                end
            end
            CMD_POP_FRONT: begin
                if (q_empty) begin
                    a_status = ST_EMPTY;
                end else begin
                    n_front = r_front + POS_ONE;
                    a_pop_f = 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (q_empty) begin
                    a_status = ST_EMPTY;
                end else begin
                    n_back  = r_back - POS_ONE;
                    a_pop_b = 1'b1;
                end
            end
            default: ;
        endcase
        rd_addr_f = f_phys(n_head, n_front + POS_ONE);
        rd_addr_b = f_phys(n_head, n_back);
        a_count   = n_back - n_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_front <= POS_NONE;
            r_back  <= POS_NONE;
        end else if (a_move) begin
            r_head  <= n_head;
            r_front <= n_front;
            r_back  <= n_back;
        end
    end

    // storage: the push of this beat lands at the same edge the reads are registered
    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (a_move && wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (r_a_word),
        .i_re      (b_en),
        .i_raddr_a (rd_addr_f),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (rd_data_f),
        .o_rdata_b (rd_data_b)
    );

    // middle stage; bypass flags mark reads of the slot being written this beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_en) begin
            r_b_vld <= r_a_vld;
        end
        if (a_move) begin
            r_b_status <= a_status;
            r_b_pop_f  <= a_pop_f;
            r_b_pop_b  <= a_pop_b;
            r_b_count  <= a_count[CW-1:0];
            r_b_empty  <= (n_back == n_front);
            r_b_byp_f  <= wr_en && (wr_addr == rd_addr_f);
            r_b_byp_b  <= wr_en && (wr_addr == rd_addr_b);
            r_b_word   <= r_a_word;
        end
    end

    // result assembly
    always_comb begin
        b_front = r_b_byp_f ? r_b_word : rd_data_f;
        b_back  = r_b_byp_b ? r_b_word : rd_data_b;
        if (r_b_empty) begin
            b_front = NONE_WORD;
            b_back  = NONE_WORD;
        end
        if (r_b_pop_f) begin
            b_popped = r_last_front;
        end else if (r_b_pop_b) begin
            b_popped = r_last_back;
        end else begin
            b_popped = NONE_WORD;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_en) begin
            r_o_vld <= r_b_vld;
        end
        if (out_en && r_b_vld) begin
            r_o_status   <= r_b_status;
            r_o_popped   <= b_popped;
            r_o_count    <= r_b_count;
            r_o_front    <= b_front;
            r_o_back     <= b_back;
            r_o_empty    <= r_b_empty;
            r_last_front <= b_front;
            r_last_back  <= b_back;
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.status       = r_o_status;
    assign o_out.popped_value = r_o_popped;
    assign o_out.count        = r_o_count;
    assign o_out.front_value  = r_o_front;
    assign o_out.back_value   = r_o_back;
    assign o_out.is_empty     = r_o_empty;

endmodule

// File: tb/sv/deq_checker.sv
// result checker for the double-ended queue buffer: predicts every result beat and compares it
// depends on deq_pkg; watches both channels of double_ended_queue_buffer_top as plain signals

module deq_checker #(
    parameter int DEPTH   = 1024,
    parameter int COUNT_W = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [deq_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_push_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [deq_pkg::STATUS_W-1:0]       i_status,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_popped_value,
    input  logic [COUNT_W-1:0]                 i_count,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_front_value,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_back_value,
    input  logic                               i_is_empty,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_refusals,
    output int                                 o_empty_pops
);
    import deq_pkg::*;

    typedef struct {
        t_status            status;
        logic [WORD_W-1:0]  popped;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  front;
        logic [WORD_W-1:0]  back;
        logic               is_empty;
    } t_deq_result;

    // shadow of the queue contents, ring addressed like the block
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                head_addr;
    int                front_pos;   // one before the first word
    int                back_pos;    // last word

    t_deq_result       result_queue [$];
    t_deq_result       oldest;
    int                fails;
    int                checked;
    int                refusals;
    int                empty_pops;

    function automatic int slot(input int pos);
        return (head_addr + pos) % DEPTH;
    endfunction

    function automatic t_deq_result queue_step(input logic [CMD_W-1:0] cmd,
                                               input logic [WORD_W-1:0] word);
        t_deq_result r;
        logic        was_empty;
        logic        is_full;
        int          held;
        r.status  = ST_OK;
        r.popped  = NONE_WORD;
        was_empty = (back_pos == front_pos);
        is_full   = (back_pos + 1 == DEPTH);
        case (cmd)
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    back_pos++;
                    shadow_words[slot(back_pos)] = word;
                end
            end
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    r.status = ST_OVERFLOW;
                end else if (front_pos == -1) begin
                    // nothing has left the front yet: shift everything up
                    head_addr = (head_addr + DEPTH - 1) % DEPTH;
                    back_pos++;
                    shadow_words[slot(0)] = word;
                end else begin
                    shadow_words[slot(front_pos)] = word;
                    front_pos--;
                end
            end
            CMD_POP_FRONT: begin
                if (was_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    front_pos++;
                    r.popped = shadow_words[slot(front_pos)];
                end
            end
            CMD_POP_BACK: begin
                if (was_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = shadow_words[slot(back_pos)];
                    back_pos--;
                end
            end
            default: begin
                // no operation, undefined codes included
            end
        endcase
        held       = back_pos - front_pos;
        r.count    = held[COUNT_W-1:0];
        r.is_empty = (held == 0);
        r.front    = NONE_WORD;
        r.back     = NONE_WORD;
        if (held != 0) begin
            r.front = shadow_words[slot(front_pos + 1)];
            r.back  = shadow_words[slot(back_pos)];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_addr  = 0;
            front_pos  = -1;
            back_pos   = -1;
            fails      = 0;
            checked    = 0;
            refusals   = 0;
            empty_pops = 0;
            result_queue.delete();
        end else begin
            // compare first so a beat never meets its own prediction
            if (i_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with no command waiting");
                    fails++;
                end else begin
                    oldest = result_queue.pop_front();
                    check_field("status", oldest.status, i_status);
                    check_field("popped_value", oldest.popped, i_popped_value);
                    check_field("count", oldest.count, i_count);
                    check_field("front_value", oldest.front, i_front_value);
                    check_field("back_value", oldest.back, i_back_value);
                    check_field("is_empty", oldest.is_empty, i_is_empty);
                    checked++;
                    if (oldest.status == ST_OVERFLOW) refusals++;
                    if (oldest.status == ST_EMPTY) empty_pops++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                result_queue.push_back(queue_step(i_cmd, i_push_value));
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_queue.size();
        o_checked    <= checked;
        o_refusals   <= refusals;
        o_empty_pops <= empty_pops;
    end

endmodule

// File: tb/sv/testbench.sv
// top of the double-ended queue buffer testbench: clock, reset, stimulus and verdict
// depends on deq_pkg, deq_if, double_ended_queue_buffer_top and deq_checker

module testbench;
    import deq_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int COUNT_W      = 11;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off to back the block up
    localparam int LIMIT_CYCLES = 250000;   // several times the slowest legal run
    localparam int DRAIN_CYCLES = 8;        // pipeline drain plus margin
    localparam int MIXED_ITEMS  = 190;      // per idling phase, four phases
    localparam logic [CMD_W-1:0] CMD_MAX = '1;

    logic clk;
    logic rst_n;

    deq_in_if                     in_ch ();
    deq_out_if #(.COUNT_W(COUNT_W)) out_ch ();

    // idling controls, percentages per cycle
    int sender_idle_pct;
    int rcv_stall_pct;

    // hold-off request: the receiver acts when its acknowledge lags the request
    int hold_req;
    int hold_ack;
    int hold_left;

    int cycle_count;

    int fail_count;
    int pending;
    int checked;
    int refusals;
    int empty_pops;

    double_ended_queue_buffer_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    deq_checker #(
        .DEPTH   (DEPTH),
        .COUNT_W (COUNT_W)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_cmd          (in_ch.cmd),
        .i_push_value   (in_ch.push_value),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_status       (out_ch.status),
        .i_popped_value (out_ch.popped_value),
        .i_count        (out_ch.count),
        .i_front_value  (out_ch.front_value),
        .i_back_value   (out_ch.back_value),
        .i_is_empty     (out_ch.is_empty),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_refusals     (refusals),
        .o_empty_pops   (empty_pops)
    );

    // 10 unit period
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a stuck handshake ends the run here
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    initial begin
        out_ch.ready = 1'b0;
        hold_ack     = 0;
        hold_left    = 0;
        forever begin
            @(posedge clk);
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // offer one beat, with a random gap first, and return once it is taken;
    // valid is never dropped between back-to-back beats
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.push_value <= word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // word with the extremes mixed in now and then
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // nop or one of the undefined codes above it
    function automatic logic [CMD_W-1:0] pick_nop_cmd(input int r);
        if (r == 0) return CMD_NOP;
        return CMD_W'($urandom_range(CMD_NOP + 1, CMD_MAX));
    endfunction

    // command drawn with a given push share; a few nops and undefined codes
    function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 4) return pick_nop_cmd(r);
        if (r < push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    // bursts that each grow or shrink the queue at random, so it stays shallow
    // and keeps running dry
    task automatic run_mixed(input int n_items);
        int push_pct;
        push_pct = 60;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) push_pct = $urandom_range(1) ? 62 : 35;
            send_beat(pick_cmd(push_pct), pick_word());
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_NOP;
        in_ch.push_value = '0;
        rst_n            = 1'b0;
        sender_idle_pct  = 0;
        rcv_stall_pct    = 0;
        hold_req         = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, undefined codes, extreme words, push front
        // before and after a front pop
        send_beat(CMD_NOP, 32'h0);
        send_beat(CMD_POP_FRONT, 32'h1);
        send_beat(CMD_POP_BACK, 32'h2);
        send_beat(CMD_W'(CMD_NOP + 1), 32'h3);
        send_beat(CMD_W'(CMD_MAX - 1), 32'h4);
        send_beat(CMD_MAX, 32'h5);
        send_beat(CMD_PUSH_BACK, 32'h7fff_ffff);
        send_beat(CMD_PUSH_FRONT, 32'h8000_0000);
        send_beat(CMD_PUSH_BACK, 32'h0);
        send_beat(CMD_PUSH_FRONT, 32'hffff_ffff);
        send_beat(CMD_MAX, 32'haaaa_aaaa);
        send_beat(CMD_POP_FRONT, 32'h0);
        send_beat(CMD_PUSH_FRONT, 32'h5555_5555);
        send_beat(CMD_POP_FRONT, 32'h0);
        send_beat(CMD_POP_FRONT, 32'h0);
        send_beat(CMD_PUSH_FRONT, 32'h1234_5678);
        send_beat(CMD_POP_BACK, 32'h0);
        send_beat(CMD_POP_BACK, 32'h0);
        send_beat(CMD_POP_FRONT, 32'h0);
        send_beat(CMD_POP_FRONT, 32'h0);
        send_beat(CMD_POP_BACK, 32'h0);
        send_beat(CMD_PUSH_BACK, 32'hdead_beef);
        send_beat(CMD_POP_BACK, 32'h0);

        // random mix under each idling pattern; the long hold-off goes in
        // the phase where the sender never rests
        sender_idle_pct = 0;
        rcv_stall_pct   = 0;
        run_mixed(MIXED_ITEMS / 4);
        hold_req <= hold_req + 1;
        run_mixed(MIXED_ITEMS - MIXED_ITEMS / 4);

        sender_idle_pct = 78;
        rcv_stall_pct   = 0;
        run_mixed(MIXED_ITEMS);

        sender_idle_pct = 0;
        rcv_stall_pct   = 78;
        run_mixed(MIXED_ITEMS);

        sender_idle_pct = 38;
        rcv_stall_pct   = 38;
        run_mixed(MIXED_ITEMS);

        in_ch.valid   <= 1'b0;
        rcv_stall_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d result beats over all idling patterns and a long output hold-off,",
                 checked);
        $display("with %0d refused pushes and %0d pops on an empty queue",
                 refusals, empty_pops);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/deq_pkg.sv
hdl/deq_if.sv
hdl/deq_ram.sv
hdl/double_ended_queue_buffer_top.sv
tb/sv/deq_checker.sv
tb/sv/testbench.sv
